>>> rtl/core/rmf_pkg.sv
// Shared constants, types and state codes for the running median filter.
// No dependencies; used by every module under rtl/core.

package rmf_pkg;

    // Window depth and derived widths
    localparam int MAX_WINDOW = 9;
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    // Field widths of the stream payloads
    localparam int SAMPLE_W   = 64;
    localparam int WIN_W      = 4;
    localparam int FILL_W     = 4;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 1;

    // Command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_EMIT
    } state_t;

    // Comparator flags
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

>>> rtl/core/rmf_cmp.sv
// Shared signed 64-bit comparator used by every sort step.
// Depends on rmf_pkg for widths and the result struct.

module rmf_cmp (
    input  logic [rmf_pkg::SAMPLE_W-1:0] a,
    input  logic [rmf_pkg::SAMPLE_W-1:0] b,
    output rmf_pkg::cmp_res_t            res
);
    import rmf_pkg::*;

    // Compare as two's complement values
    always_comb
    begin
        res.eq = (a == b);
        res.gt = ($signed(a) > $signed(b));
    end

endmodule

>>> rtl/core/rmf_store.sv
// Sample storage: the age-ordered ring and the value-ordered list.
// Depends on rmf_pkg for depth and widths. Contents are undefined until written.

module rmf_store (
    input  logic                         clk,
    input  logic                         ring_we,
    input  logic [rmf_pkg::IDX_W-1:0]    ring_addr,
    input  logic [rmf_pkg::SAMPLE_W-1:0] ring_wdata,
    output logic [rmf_pkg::SAMPLE_W-1:0] ring_rdata,
    input  logic                         srt_we,
    input  logic [rmf_pkg::IDX_W-1:0]    srt_waddr,
    input  logic [rmf_pkg::SAMPLE_W-1:0] srt_wdata,
    input  logic [rmf_pkg::IDX_W-1:0]    srt_raddr,
    output logic [rmf_pkg::SAMPLE_W-1:0] srt_rdata
);
    import rmf_pkg::*;

    logic [SAMPLE_W-1:0] ring_reg [MAX_WINDOW];
    logic [SAMPLE_W-1:0] srt_reg  [MAX_WINDOW];

    // Write the ring at the current write slot
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_reg[ring_addr] <= ring_wdata;
        end
    end

    // Write one slot of the sorted list per cycle
    always_ff @(posedge clk)
    begin
        if (srt_we)
        begin
            srt_reg[srt_waddr] <= srt_wdata;
        end
    end

    // Single read port on each file
    assign ring_rdata = ring_reg[ring_addr];
    assign srt_rdata  = srt_reg[srt_raddr];

endmodule

>>> rtl/core/running_median_filter_unit.sv
// Top level of the running median filter: stream ports, sequencer, output register.
// Depends on rmf_pkg, rmf_cmp (shared comparator) and rmf_store (ring and sorted list).
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  tdata: sample; tuser: command, sample_present
//  m_*       out        m_tvalid / m_tready  tdata: median_value, fill_count; tuser: input_error
//  cfg_*     in         cfg_valid / cfg_ready cfg_data: window_size
//
// Request steps: a clear is taken in the idle step, a missing sample goes straight to the
// emit step, and a push while the window fills walks the sorted list down to the new
// sample's rank. All sort steps share the single comparator: a full-window push first
// walks the whole sorted list to drop the oldest sample, then walks it back down only as
// far as the new sample's rank.
// Reset empties the window and sets window_size to 1; the stores themselves are not cleared.
// A result waiting on m_tready does not block the next request; the sequencer holds in
// its emit step only if the previous result is still unread.

module running_median_filter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rmf_pkg::IN_DATA_W-1:0]   s_tdata,   // [63:0] sample
    input  logic [rmf_pkg::IN_USER_W-1:0]   s_tuser,   // [0] command, [1] sample_present
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rmf_pkg::OUT_DATA_W-1:0]  m_tdata,   // [63:0] median_value,
                                                       // [67:64] fill_count, [71:68] zero
    output logic [rmf_pkg::OUT_USER_W-1:0]  m_tuser,   // [0] input_error
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rmf_pkg::WIN_W-1:0]       cfg_data   // window_size
);
    import rmf_pkg::*;

    state_t              state_reg,   state_next;
    logic [WIN_W-1:0]    window_reg,  window_next;
    logic [CNT_W-1:0]    held_reg,    held_next;
    logic [IDX_W-1:0]    wpos_reg,    wpos_next;
    logic [CNT_W-1:0]    k_reg,       k_next;
    logic                found_reg,   found_next;
    logic                err_reg,     err_next;
    logic [SAMPLE_W-1:0] old_reg,     old_next;
    logic [SAMPLE_W-1:0] new_reg,     new_next;
    logic                ovalid_reg,  ovalid_next;
    logic [SAMPLE_W-1:0] omed_reg,    omed_next;
    logic [FILL_W-1:0]   ofill_reg,   ofill_next;
    logic                oerr_reg,    oerr_next;

    logic [CNT_W-1:0]    win_eff;
    logic [CNT_W-1:0]    wpos_inc;
    logic [CNT_W-1:0]    held_inc;
    logic                in_req;
    logic                cfg_req;

    logic                ring_we;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic                srt_we;
    logic [IDX_W-1:0]    srt_waddr;
    logic [SAMPLE_W-1:0] srt_wdata;
    logic [IDX_W-1:0]    srt_raddr;
    logic [SAMPLE_W-1:0] srt_rdata;
    logic [SAMPLE_W-1:0] cmp_b;
    cmp_res_t            cmp_res;

    // Storage and the shared comparator
    rmf_store u_store (
        .clk        (clk),
        .ring_we    (ring_we),
        .ring_addr  (wpos_reg),
        .ring_wdata (s_tdata[SAMPLE_W-1:0]),
        .ring_rdata (ring_rdata),
        .srt_we     (srt_we),
        .srt_waddr  (srt_waddr),
        .srt_wdata  (srt_wdata),
        .srt_raddr  (srt_raddr),
        .srt_rdata  (srt_rdata)
    );

    rmf_cmp u_cmp (
        .a   (srt_rdata),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign cmp_b = (state_reg == ST_REMOVE) ? old_reg : new_reg;

    // Saturate the configured window to 1..MAX_WINDOW
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (int'(window_reg) > MAX_WINDOW)
        begin
            win_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = CNT_W'(window_reg);
        end
    end

    assign wpos_inc = CNT_W'(wpos_reg) + CNT_W'(1);
    assign held_inc = held_reg + CNT_W'(1);

    // Handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_req    = s_tvalid && s_tready;
    assign cfg_req   = cfg_valid && cfg_ready;

    // Sequencer: next state, store controls and output register load
    always_comb
    begin
        state_next  = state_reg;
        window_next = window_reg;
        held_next   = held_reg;
        wpos_next   = wpos_reg;
        k_next      = k_reg;
        found_next  = found_reg;
        err_next    = err_reg;
        old_next    = old_reg;
        new_next    = new_reg;
        ovalid_next = ovalid_reg;
        omed_next   = omed_reg;
        ofill_next  = ofill_reg;
        oerr_next   = oerr_reg;
        ring_we     = 1'b0;
        srt_we      = 1'b0;
        srt_waddr   = k_reg[IDX_W-1:0];
        srt_wdata   = srt_rdata;
        srt_raddr   = k_reg[IDX_W-1:0];

        // Drop the output once taken
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    if (s_tuser[0] == CMD_CLEAR)
                    begin
                        held_next = '0;
                        wpos_next = '0;
                    end
                    else if (!s_tuser[1])
                    begin
                        err_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        // Capture the evicted sample and overwrite its ring slot
                        err_next = 1'b0;
                        new_next = s_tdata[SAMPLE_W-1:0];
                        old_next = ring_rdata;
                        ring_we  = 1'b1;
                        if (held_reg >= win_eff)
                        begin
                            wpos_next  = (wpos_inc == win_eff) ? '0
                                                               : wpos_inc[IDX_W-1:0];
                            k_next     = '0;
                            found_next = 1'b0;
                            state_next = ST_REMOVE;
                        end
                        else
                        begin
                            held_next  = held_inc;
                            wpos_next  = (held_inc == win_eff) ? '0
                                                               : held_inc[IDX_W-1:0];
                            k_next     = held_reg;
                            state_next = ST_INSERT;
                        end
                    end
                end
                if (cfg_req)
                begin
                    window_next = cfg_data;
                    held_next   = '0;
                    wpos_next   = '0;
                end
            end

            ST_REMOVE:
            begin
                // Find the evicted value and close the gap behind it
                if (found_reg)
                begin
                    srt_we    = 1'b1;
                    srt_waddr = IDX_W'(k_reg - CNT_W'(1));
                    srt_wdata = srt_rdata;
                end
                else if (cmp_res.eq)
                begin
                    found_next = 1'b1;
                end
                if (k_reg == held_reg - CNT_W'(1))
                begin
                    k_next     = held_reg - CNT_W'(1);
                    state_next = ST_INSERT;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end

            ST_INSERT:
            begin
                // Shift larger entries up until the new sample fits
                srt_raddr = IDX_W'(k_reg - CNT_W'(1));
                srt_we    = 1'b1;
                if ((k_reg != '0) && cmp_res.gt)
                begin
                    srt_wdata = srt_rdata;
                    k_next    = k_reg - CNT_W'(1);
                end
                else
                begin
                    srt_wdata  = new_reg;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // Read the middle rank and load the output once it is free
                srt_raddr = IDX_W'(held_reg >> 1);
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    omed_next   = err_reg ? '0 : srt_rdata;
                    ofill_next  = FILL_W'(held_reg);
                    oerr_next   = err_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            window_reg <= WIN_W'(1);
            held_reg   <= '0;
            wpos_reg   <= '0;
            k_reg      <= '0;
            found_reg  <= 1'b0;
            err_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            window_reg <= window_next;
            held_reg   <= held_next;
            wpos_reg   <= wpos_next;
            k_reg      <= k_next;
            found_reg  <= found_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        old_reg   <= old_next;
        new_reg   <= new_next;
        omed_reg  <= omed_next;
        ofill_reg <= ofill_next;
        oerr_reg  <= oerr_next;
    end

    // Output stream
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {(OUT_DATA_W - SAMPLE_W - FILL_W)'(0), ofill_reg, omed_reg};
    assign m_tuser  = OUT_USER_W'(oerr_reg);

endmodule

>>> dv/running_median_checker.sv
// Checker for the running median filter: watches the request, result and window
// channels, predicts each result and compares it field by field. Depends on rmf_pkg.
`timescale 1ns / 100ps

module running_median_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,     // [63:0] sample
    input  logic [1:0]  s_tuser,     // [0] command, [1] sample_present
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,     // [63:0] median_value, [67:64] fill_count
    input  logic [0:0]  m_tuser,     // [0] input_error
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,    // window_size
    output int          pending_results,
    output int          mismatch_count
);
    import rmf_pkg::*;

    typedef struct packed {
        logic signed [63:0] median_value;
        logic [3:0]         fill_count;
        logic               input_error;
    } median_result_t;

    // Shadow copy of the filter state
    logic signed [63:0] window_ring [MAX_WINDOW];
    logic [3:0]         held_count;
    logic [3:0]         write_pos;
    logic [3:0]         window_reg;
    median_result_t     expected_medians [$];
    int                 errors;

    // Window in use: zero acts as one, saturate above the ring depth
    function automatic int active_window();
        if (window_reg == 4'd0)
            return 1;
        if (window_reg > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(window_reg);
    endfunction

    // Sort the held samples (signed) and pick rank n/2, the upper median for even n
    function automatic logic signed [63:0] middle_of_window(input int n);
        logic signed [63:0] sorted [MAX_WINDOW];
        logic signed [63:0] key;
        int                 k;
        for (int i = 0; i < n; i++)
            sorted[i] = window_ring[i];
        for (int i = 1; i < n; i++)
        begin
            key = sorted[i];
            k   = i;
            while (k > 0 && sorted[k-1] > key)
            begin
                sorted[k] = sorted[k-1];
                k--;
            end
            sorted[k] = key;
        end
        return sorted[n/2];
    endfunction

    // Apply one push request to the shadow state and return its result
    function automatic median_result_t predict_push(input logic present,
                                                    input logic signed [63:0] smp);
        median_result_t r;
        int             w;
        w = active_window();
        if (!present)
        begin
            r.median_value = '0;
            r.fill_count   = held_count;
            r.input_error  = 1'b1;
            return r;
        end
        if (held_count > w)
            held_count = 4'(w);
        if (held_count < w)
        begin
            window_ring[held_count] = smp;
            held_count = held_count + 4'd1;
            write_pos  = 4'(held_count % w);
        end
        else
        begin
            if (write_pos >= w)
                write_pos = 4'd0;
            window_ring[write_pos] = smp;
            write_pos = 4'((write_pos + 1) % w);
        end
        r.median_value = middle_of_window(int'(held_count));
        r.fill_count   = held_count;
        r.input_error  = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        median_result_t exp_r;
        if (!rst_n)
        begin
            held_count = '0;
            write_pos  = '0;
            window_reg = 4'd1;
            errors     = 0;
            expected_medians.delete();
            pending_results <= 0;
            mismatch_count  <= 0;
        end
        else
        begin
            // Compare an accepted result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_medians.size() == 0)
                begin
                    $error("result with no request pending: median_value %0d",
                           $signed(m_tdata[63:0]));
                    errors++;
                end
                else
                begin
                    exp_r = expected_medians.pop_front();
                    if (m_tdata[63:0] !== exp_r.median_value)
                    begin
                        $error("median_value: expected %0d, got %0d",
                               exp_r.median_value, $signed(m_tdata[63:0]));
                        errors++;
                    end
                    if (m_tdata[67:64] !== exp_r.fill_count)
                    begin
                        $error("fill_count: expected %0d, got %0d",
                               exp_r.fill_count, m_tdata[67:64]);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_r.input_error)
                    begin
                        $error("input_error: expected %0b, got %0b",
                               exp_r.input_error, m_tuser[0]);
                        errors++;
                    end
                end
            end

            // A window write also empties the history
            if (cfg_valid && cfg_ready)
            begin
                window_reg = cfg_data;
                held_count = '0;
                write_pos  = '0;
            end

            // Predict the accepted request
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == CMD_CLEAR)
                begin
                    held_count = '0;
                    write_pos  = '0;
                end
                else
                    expected_medians.push_back(predict_push(s_tuser[1], s_tdata));
            end

            pending_results <= expected_medians.size();
            mismatch_count  <= errors;
        end
    end

endmodule

>>> dv/tb_running_median_filter_unit.sv
// Testbench top for running_median_filter_unit: clock, reset, request and window
// stimulus, result back-pressure and verdict. Depends on rmf_pkg and running_median_checker.
`timescale 1ns / 100ps

module tb_running_median_filter_unit;
    import rmf_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 30;
    localparam int NUM_PHASES   = 16;
    localparam int PHASE_ITEMS  = 89;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [63:0] sample
    logic [1:0]  s_tuser;   // [0] command, [1] sample_present
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;   // [63:0] median_value, [67:64] fill_count, [71:68] zero
    logic [0:0]  m_tuser;   // [0] input_error
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;  // window_size

    int   pending_results;
    int   mismatch_count;
    logic idle_enable = 1'b0;
    int   cycle_count = 0;
    int   push_count = 0;
    int   missing_count = 0;
    int   clear_count = 0;
    int   window_writes = 0;
    int   sink_gap = 0;

    logic [3:0] phase_windows [NUM_PHASES];

    running_median_filter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    running_median_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result back-pressure in random bursts while idling is enabled
    always @(posedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap = sink_gap - 1;
            m_tready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            sink_gap = $urandom_range(1, 7) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Sample mix: full-range words, small values for ties, extremes, 16-bit values
    function automatic logic [63:0] random_sample();
        case ($urandom_range(0, 5))
            2: return 64'(int'($urandom_range(0, 8)) - 4);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: return 64'h7fff_ffff_ffff_ffff;
                    1: return 64'h8000_0000_0000_0000;
                    2: return 64'h0;
                    default: return '1;
                endcase
            end
            4: return 64'(shortint'($urandom));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one request, with an optional random gap before it
    task automatic send_request(input logic cmd, input logic present, input logic [63:0] smp);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {present, cmd};
        s_tdata  <= smp;
        do @(posedge clk); while (!s_tready);
        if (cmd == CMD_CLEAR)
            clear_count++;
        else if (!present)
            missing_count++;
        else
            push_count++;
    endtask

    task automatic push_sample(input logic [63:0] smp);
        send_request(CMD_PUSH, 1'b1, smp);
    endtask

    task automatic push_missing();
        send_request(CMD_PUSH, 1'b0, random_sample());
    endtask

    // Hold requests until every result is back, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [3:0] w);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_writes++;
    endtask

    // Random phase: mostly pushes, some missing samples and rare clears
    task automatic run_phase(input logic [3:0] w, input int n, input logic idle_on);
        int r;
        write_window(w);
        idle_enable <= idle_on;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_request(CMD_CLEAR, 1'($urandom), random_sample());
            else if (r < 10)
                push_missing();
            else
                push_sample(random_sample());
            if (i == n / 2 && $urandom_range(0, 2) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        phase_windows = '{4'd15, 4'd1, 4'd9, 4'd0, 4'd2, 4'd3, 4'd4, 4'd5,
                          4'd6, 4'd7, 4'd8, 4'($urandom), 4'($urandom), 4'd14, 4'd10, 4'd9};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full window: extremes, fill, ring wrap, missing sample, clear
        write_window(4'd9);
        push_sample(64'h7fff_ffff_ffff_ffff);
        push_sample(64'h8000_0000_0000_0000);
        push_sample(64'h0);
        push_sample('1);
        push_sample(64'h1);
        push_missing();
        push_sample(64'd5);
        push_sample(64'd7);
        push_sample(-64'sd3);
        push_sample(64'd2);
        push_sample(64'd100);
        push_sample(-64'sd100);
        send_request(CMD_CLEAR, 1'b1, 64'h0);
        push_missing();
        push_sample(64'd42);

        // Window of zero acts as one
        write_window(4'd0);
        push_sample(64'd7);
        push_sample(-64'sd7);
        push_missing();

        // Even window: upper median
        write_window(4'd2);
        push_sample(64'd10);
        push_sample(64'd20);
        push_sample(64'd5);
        send_request(CMD_CLEAR, 1'b0, 64'h0);

        // Random phases; idling off in one middle phase and in the last one
        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(phase_windows[p], PHASE_ITEMS, (p != 5) && (p != NUM_PHASES - 1));

        wait_idle();
        $display("covered %0d requests: %0d pushes, %0d missing samples, %0d clears",
                 push_count + missing_count + clear_count, push_count, missing_count,
                 clear_count);
        $display("window written %0d times, including 0, 15 and the full depth",
                 window_writes);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> running_median_filter_unit.f
rtl/core/rmf_pkg.sv
rtl/core/rmf_cmp.sv
rtl/core/rmf_store.sv
rtl/core/running_median_filter_unit.sv
dv/running_median_checker.sv
dv/tb_running_median_filter_unit.sv
